>>> hdl/bmhq_pkg.sv
// Package for the binary max-heap queue: widths, command codes, state enum.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;
	localparam int Depth = 1024;
	localparam int AddrW = $clog2(Depth);
	localparam int CntW = AddrW + 1;
	localparam int ValW = 32;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [0:0] cmd;
		logic signed [ValW-1:0] value;
		logic [AddrW-1:0] slot;
	} req_t;

	typedef struct packed {
		logic ok;
		logic signed [ValW-1:0] removed_value;
		logic signed [ValW-1:0] top_value;
		logic [CntW-1:0] count;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RM_RD,
		ST_RM_WAIT,
		ST_UP_RD,
		ST_UP_WAIT,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_WAIT,
		ST_DN_CMP,
		ST_TOP_RD,
		ST_TOP_WAIT,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

>>> hdl/bmhq_if.sv
// Valid/ready channel interfaces for the heap queue.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bmhq_req_if;
	logic valid;
	logic ready;
	bmhq_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface bmhq_rsp_if;
	logic valid;
	logic ready;
	bmhq_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/bmhq_ram.sv
// Single-port-write, dual-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
	parameter int Words = 1024,
	parameter int Width = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Words)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Words)-1:0] raddr_a,
	input wire logic [$clog2(Words)-1:0] raddr_b,
	output logic [Width-1:0] rdata_a,
	output logic [Width-1:0] rdata_b
);
	logic [Width-1:0] mem [Words];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

>>> hdl/binary_max_heap_queue_top.sv
// Top level of the binary max-heap queue: sequencer around the heap RAM.
// Depends on bmhq_pkg, bmhq_if and bmhq_ram.
//
//  channel   | dir | handshake        | payload
//  req       | in  | valid/ready      | cmd, value, slot
//  rsp       | out | valid/ready      | ok, removed_value, top_value, count
//  cfg       | in  | cfg_we           | cfg_data = capacity
//
// One item at a time. From the transfer to the result: for each level a value
// moves, a read of the RAM, a wait for its registered data and a compare with
// the write; then the checks that end the upward and downward walks, a read
// of the top and the load of the output register, and on a remove, before
// the walk, a fetch of the hole and the last entry. A walk covers at most 10
// levels for 1024 entries; a refused item skips the walks and goes straight
// to the top read. Reset clears the count and sets the capacity to 1024; heap
// RAM is not cleared since only filled slots are read. A result waits in the
// output register while rsp is stalled; the next request transfers only once
// that result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module binary_max_heap_queue_top (
	input wire logic clk,
	input wire logic arst_n,
	bmhq_req_if.sink req,
	bmhq_rsp_if.source rsp,
	input wire logic cfg_we,
	input wire logic [bmhq_pkg::CntW-1:0] cfg_data
);
	import bmhq_pkg::*;

	state_t state_q, state_nx;
	logic [CntW-1:0] cap_q, cnt_q;
	logic [AddrW-1:0] idx_q;
	logic signed [ValW-1:0] cur_q, removed_q;
	logic ok_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic we;
	logic [AddrW-1:0] waddr, ra, rb;
	logic [ValW-1:0] wdata, rda, rdb;

	bmhq_ram #(.Words(Depth), .Width(ValW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
	);

	logic [CntW-1:0] limit;
	logic accept;
	logic [CntW:0] lidx, ridx;
	logic has_l, has_r, pick_r, up_swap, dn_swap;
	logic [AddrW-1:0] parent, big;
	logic signed [ValW-1:0] big_val;
	logic signed [ValW-1:0] top_now;

	assign limit = (cap_q > CntW'(Depth)) ? CntW'(Depth) : cap_q;
	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign accept = req.valid && req.ready;
	assign parent = (idx_q - AddrW'(1)) >> 1;
	assign lidx = {1'b0, idx_q, 1'b1};
	assign ridx = lidx + (CntW+1)'(1);
	assign has_l = lidx < {1'b0, cnt_q};
	assign has_r = ridx < {1'b0, cnt_q};
	assign pick_r = has_r && ($signed(rdb) > $signed(rda));
	assign big = pick_r ? AddrW'(ridx) : AddrW'(lidx);
	assign big_val = pick_r ? $signed(rdb) : $signed(rda);
	assign up_swap = $signed(rda) < cur_q;
	assign dn_swap = big_val > cur_q;

	// slot 0 is written and read at the same edge when cur comes to rest there
	assign top_now = (cnt_q == '0) ? '0 :
		(ok_q && idx_q == '0) ? cur_q : $signed(rda);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.payload.cmd == CMD_INSERT) begin
						state_nx = ({1'b0, cnt_q} < {1'b0, limit}) ? ST_UP_RD : ST_TOP_RD;
					end else begin
						state_nx = ({1'b0, req.payload.slot} < cnt_q) ? ST_RM_RD : ST_TOP_RD;
					end
				end
			end
			ST_RM_RD: state_nx = ST_RM_WAIT;
			ST_RM_WAIT: state_nx = ({1'b0, idx_q} < cnt_q) ? ST_UP_RD : ST_TOP_RD;
			ST_UP_RD: state_nx = (idx_q == '0) ? ST_DN_RD : ST_UP_WAIT;
			ST_UP_WAIT: state_nx = ST_UP_CMP;
			ST_UP_CMP: state_nx = up_swap ? ST_UP_RD : ST_DN_RD;
			ST_DN_RD: state_nx = has_l ? ST_DN_WAIT : ST_TOP_RD;
			ST_DN_WAIT: state_nx = ST_DN_CMP;
			ST_DN_CMP: state_nx = dn_swap ? ST_DN_RD : ST_TOP_RD;
			ST_TOP_RD: state_nx = ST_TOP_WAIT;
			ST_TOP_WAIT: state_nx = ST_OUT;
			ST_OUT: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		ra = idx_q;
		rb = idx_q;
		case (state_q)
			ST_RM_RD: begin
				ra = idx_q;
				rb = AddrW'(cnt_q - CntW'(1));
			end
			ST_RM_WAIT: begin
				// drop last entry into the hole
				we = 1'b1;
				waddr = idx_q;
				wdata = rdb;
			end
			ST_UP_RD: ra = parent;
			ST_UP_WAIT: ra = parent;
			ST_UP_CMP: begin
				// pull parent down; cur goes to parent next round or stays
				we = 1'b1;
				waddr = idx_q;
				wdata = up_swap ? rda : cur_q;
			end
			ST_DN_RD: begin
				ra = AddrW'(lidx);
				rb = AddrW'(ridx);
			end
			ST_DN_WAIT: begin
				// hold the child addresses so their data stays on the read ports
				ra = AddrW'(lidx);
				rb = AddrW'(ridx);
			end
			ST_DN_CMP: begin
				we = 1'b1;
				waddr = idx_q;
				wdata = dn_swap ? big_val : cur_q;
			end
			ST_TOP_RD: begin
				// finish the walk: cur lands where it stopped
				we = (cnt_q != '0) && ok_q;
				waddr = idx_q;
				wdata = cur_q;
				ra = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q <= CntW'(Depth);
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (accept && req.payload.cmd == CMD_INSERT
					&& ({1'b0, cnt_q} < {1'b0, limit})) begin
				cnt_q <= cnt_q + CntW'(1);
			end
			if (state_q == ST_RM_RD) begin
				cnt_q <= cnt_q - CntW'(1);
			end
			if (state_q == ST_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath; RAM is written with cur at its resting place in ST_TOP_RD
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ok_q <= 1'b0;
				removed_q <= '0;
				if (accept) begin
					cur_q <= req.payload.value;
					if (req.payload.cmd == CMD_INSERT) begin
						idx_q <= AddrW'(cnt_q);
						ok_q <= {1'b0, cnt_q} < {1'b0, limit};
					end else begin
						idx_q <= req.payload.slot;
						ok_q <= {1'b0, req.payload.slot} < cnt_q;
					end
				end
			end
			ST_RM_WAIT: begin
				removed_q <= rda;
				cur_q <= rdb;
			end
			ST_UP_CMP: if (up_swap) idx_q <= parent;
			ST_DN_CMP: if (dn_swap) idx_q <= big;
			ST_TOP_WAIT: begin
				rsp_q.ok <= ok_q;
				rsp_q.removed_value <= removed_q;
				rsp_q.top_value <= top_now;
				rsp_q.count <= cnt_q;
			end
			default: ;
		endcase
	end

	// refused items skip the walk; their top comes from a quick read
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	logic signed [ValW-1:0] top_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_TOP_WAIT) begin
			top_q <= top_now;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CntW'(Depth))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !req.ready)
		else $error("request taken with result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> rsp_valid_q)
		else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.ok && rsp_q.count != '0) |-> (top_q == rsp_q.top_value))
		else $error("top mismatch");
endmodule
`default_nettype wire
